[rtl/pva_pkg.sv]
// shared types, constants and the cordic turn table for the bin phase advance block
// no dependencies
package pva_pkg;

  localparam int CORDIC_STEPS   = 24;
  localparam int GUARD_BITS     = 6;
  localparam int CW             = 34;   // cordic x/y width
  localparam int ZW             = 33;   // cordic angle width
  localparam int IDX_W          = 11;
  localparam int SAMP_W         = 24;
  localparam int DEF_FFT_SIZE   = 2048;
  localparam int DEF_NUM_BINS   = 1025;
  localparam int DEF_PHASE_BITS = 24;
  localparam logic signed [63:0] INV_GAIN2_Q30 = 64'sd395948876;

  // sideband that travels with each word through both cordic chains
  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [SAMP_W-1:0] re;
    logic signed [SAMP_W-1:0] im;
    logic                     last;
    logic                     pv;     // phase memories valid when accepted
    logic                     zero;   // bin exactly zero
    logic                     proc;   // rebuilt from new phase
  } side_t;

  function automatic logic [31:0] atan_turn(input int step);
    case (step)
      0:  return 32'h20000000;
      1:  return 32'h12E4051E;
      2:  return 32'h09FB385B;
      3:  return 32'h051111D4;
      4:  return 32'h028B0D43;
      5:  return 32'h0145D7E1;
      6:  return 32'h00A2F61E;
      7:  return 32'h00517C55;
      8:  return 32'h0028BE53;
      9:  return 32'h00145F2F;
      10: return 32'h000A2F98;
      11: return 32'h000517CC;
      12: return 32'h00028BE6;
      13: return 32'h000145F3;
      14: return 32'h0000A2FA;
      15: return 32'h0000517D;
      16: return 32'h000028BE;
      17: return 32'h0000145F;
      18: return 32'h00000A30;
      19: return 32'h00000518;
      20: return 32'h0000028C;
      21: return 32'h00000146;
      22: return 32'h000000A3;
      23: return 32'h00000051;
      default: return 32'h0;
    endcase
  endfunction

endpackage

[rtl/pva_cordic_cell.sv]
// one cordic micro-rotation cell, vectoring or rotating mode
// depends on pva_pkg
module pva_cordic_cell
  import pva_pkg::*;
#(
  parameter int STEP = 0,
  parameter bit VECT = 1'b1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 v_in,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  input  side_t                side_in,
  output logic                 v_r,
  output logic signed [CW-1:0] x_r,
  output logic signed [CW-1:0] y_r,
  output logic signed [ZW-1:0] z_r,
  output side_t                side_r
);

  localparam logic signed [ZW-1:0] ATAN = $signed({1'b0, atan_turn(STEP)});

  logic                 neg;
  logic signed [CW-1:0] xs, ys, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_nxt;

  always_comb begin
    // vectoring drives y to zero, rotating drives z to zero
    neg   = VECT ? ~y_in[CW-1] : z_in[ZW-1];
    xs    = x_in >>> STEP;
    ys    = y_in >>> STEP;
    x_nxt = neg ? x_in + ys : x_in - ys;
    y_nxt = neg ? y_in - xs : y_in + xs;
    z_nxt = neg ? z_in + ATAN : z_in - ATAN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
      side_r <= side_in;
    end
  end

endmodule

[rtl/pva_phase_update.sv]
// per-bin phase memories, deviation, hop scaling and scaled phase accumulation
// depends on pva_pkg
module pva_phase_update
  import pva_pkg::*;
#(
  parameter int FFT_SIZE   = DEF_FFT_SIZE,
  parameter int NUM_BINS   = DEF_NUM_BINS,
  parameter int PHASE_BITS = DEF_PHASE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic [11:0]           analysis_hop,
  input  logic [19:0]           synthesis_hop_q8,
  input  logic [23:0]           hop_ratio_q16,
  input  logic                  in_v,
  input  side_t                 in_side,
  input  logic [PHASE_BITS-1:0] in_ph,
  input  logic signed [CW-1:0]  in_mag,
  output logic                  s4_v_r,
  output side_t                 s4_side_r,
  output logic [PHASE_BITS-1:0] s4_sc_r,
  output logic signed [CW-1:0]  s4_mag_r
);

  localparam int PB  = PHASE_BITS;
  localparam int AW  = $clog2(NUM_BINS);
  localparam int LF  = $clog2(FFT_SIZE);
  localparam int EPW = IDX_W + 12;
  localparam int NPW = IDX_W + 20;
  localparam int PRW = PB + 25;

  logic [PB-1:0] raw_mem [NUM_BINS];
  logic [PB-1:0] sc_mem  [NUM_BINS];

  logic          inr0;
  logic [AW-1:0] a0;

  // stage 1
  logic                 s1_v_r, s1_inr_r;
  side_t                s1_side_r;
  logic [PB-1:0]        s1_ph_r, raw_rd_r, sc_rd_r;
  logic signed [CW-1:0] s1_mag_r;
  logic [AW-1:0]        s1_a_r;
  logic [EPW-1:0]       s1_exp_r;
  logic [NPW-1:0]       s1_nom_r;
  logic [EPW+PB-1:0]    exp_full;
  logic [NPW+PB-1:0]    nom_full;
  logic [PB-1:0]        dev;

  // stage 2
  logic                 s2_v_r, s2_inr_r;
  side_t                s2_side_r;
  logic [PB-1:0]        s2_ph_r, s2_dev_r, s2_nom_r, s2_old_r;
  logic signed [CW-1:0] s2_mag_r;
  logic [AW-1:0]        s2_a_r;

  // stage 3
  logic                 s3_v_r, s3_inr_r;
  side_t                s3_side_r, s3_side_out;
  logic [PB-1:0]        s3_ph_r, s3_nom_r, s3_old_r;
  logic signed [CW-1:0] s3_mag_r;
  logic [AW-1:0]        s3_a_r;
  logic signed [PRW-1:0] s3_prod_r, rnd, adjv;
  logic [PB-1:0]        old_f, sc_new;
  logic                 wr3;

  // write history for forwarding
  logic          w4_v_r, w5_v_r, w6_v_r;
  logic [AW-1:0] w4_a_r, w5_a_r, w6_a_r;
  logic [PB-1:0] w5_sc_r, w6_sc_r;

  always_comb begin
    inr0 = 32'(in_side.idx) < 32'(NUM_BINS);
    a0   = AW'(in_side.idx);
  end

  // read-first: a word reads its own entry before overwriting the raw phase
  always_ff @(posedge clk) begin
    if (en) begin
      if (in_v && inr0) begin
        raw_mem[a0] <= in_ph;
      end
      raw_rd_r <= raw_mem[a0];
      sc_rd_r  <= sc_mem[a0];
      if (wr3) begin
        sc_mem[s3_a_r] <= sc_new;
      end
    end
  end

  always_comb begin
    exp_full = {s1_exp_r, {PB{1'b0}}};
    nom_full = {s1_nom_r, {PB{1'b0}}};
    dev      = s1_ph_r - raw_rd_r - exp_full[LF +: PB];
  end

  always_comb begin
    // newest pending write to the same bin wins over the memory read
    if (w4_v_r && w4_a_r == s3_a_r) begin
      old_f = s4_sc_r;
    end else if (w5_v_r && w5_a_r == s3_a_r) begin
      old_f = w5_sc_r;
    end else if (w6_v_r && w6_a_r == s3_a_r) begin
      old_f = w6_sc_r;
    end else begin
      old_f = s3_old_r;
    end
    rnd    = s3_prod_r + PRW'(32768);
    adjv   = rnd >>> 16;
    sc_new = s3_side_r.pv ? (old_f + s3_nom_r + adjv[PB-1:0]) : s3_ph_r;
    wr3    = en && s3_v_r && s3_inr_r;
    s3_side_out      = s3_side_r;
    s3_side_out.proc = s3_side_r.pv && s3_inr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      w4_v_r <= 1'b0;
      w5_v_r <= 1'b0;
      w6_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_v;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      w4_v_r <= s3_v_r && s3_inr_r;
      w5_v_r <= w4_v_r;
      w6_v_r <= w5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side_r <= in_side;
      s1_ph_r   <= in_ph;
      s1_mag_r  <= in_mag;
      s1_inr_r  <= inr0;
      s1_a_r    <= a0;
      s1_exp_r  <= EPW'(in_side.idx) * EPW'(analysis_hop);
      s1_nom_r  <= NPW'(in_side.idx) * NPW'(synthesis_hop_q8);

      s2_side_r <= s1_side_r;
      s2_ph_r   <= s1_ph_r;
      s2_mag_r  <= s1_mag_r;
      s2_inr_r  <= s1_inr_r;
      s2_a_r    <= s1_a_r;
      s2_dev_r  <= dev;
      s2_nom_r  <= nom_full[LF + 8 +: PB];
      s2_old_r  <= sc_rd_r;

      s3_side_r <= s2_side_r;
      s3_ph_r   <= s2_ph_r;
      s3_mag_r  <= s2_mag_r;
      s3_inr_r  <= s2_inr_r;
      s3_a_r    <= s2_a_r;
      s3_nom_r  <= s2_nom_r;
      s3_old_r  <= s2_old_r;
      s3_prod_r <= PRW'($signed(s2_dev_r)) * PRW'($signed({1'b0, hop_ratio_q16}));

      s4_side_r      <= s3_side_out;
      s4_sc_r        <= sc_new;
      s4_mag_r       <= s3_mag_r;
      w4_a_r         <= s3_a_r;
      w5_a_r         <= w4_a_r;
      w5_sc_r        <= s4_sc_r;
      w6_a_r         <= w5_a_r;
      w6_sc_r        <= w5_sc_r;
    end
  end

endmodule

[rtl/phase_vocoder_bin_phase_advance.sv]
// top level of the phase vocoder bin phase advance block
// depends on pva_pkg, pva_cordic_cell, pva_phase_update
//
// usage
//   - one complex bin word per cycle on the in_ channel (valid/stall); a word
//     with in_operation set is a restart: it yields no result and marks the
//     phase memories not yet valid for the next frame
//   - every other word yields exactly one result word on the out_ channel,
//     in order, carrying the bin index and last flag along
//   - the path from acceptance to out_valid runs through 24 vectoring cordic
//     cells, 4 phase update stages, 24 rotating cordic cells, 1 descale
//     multiply stage and the output register
//   - throughput is one word per cycle unless out_stall freezes the pipe; the
//     two cell rows and phase memory read-modify-write take a word every cycle
//   - repeated bins within a few cycles are handled by forwarding the newest
//     pending scaled phase, so any index order is accepted
//   - when out_stall holds a waiting result the whole pipe freezes and
//     in_stall rises in the same cycle; nothing is dropped
//   - reset clears the pipe valids, the hop registers to their defaults and
//     the phases valid flag; phase memory contents are not cleared
//   - user must write apb registers only while the block is idle; not enforced
module phase_vocoder_bin_phase_advance
  import pva_pkg::*;
#(
  parameter int FFT_SIZE   = DEF_FFT_SIZE,
  parameter int NUM_BINS   = DEF_NUM_BINS,
  parameter int PHASE_BITS = DEF_PHASE_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input words
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_operation,
  input  logic [IDX_W-1:0]         in_bin_index,
  input  logic signed [SAMP_W-1:0] in_bin_real,
  input  logic signed [SAMP_W-1:0] in_bin_imag,
  input  logic                     in_last_bin,
  // result words
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         out_index,
  output logic signed [SAMP_W-1:0] out_real,
  output logic signed [SAMP_W-1:0] out_imag,
  output logic                     out_last,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam int PB = PHASE_BITS;
  localparam int NS = CORDIC_STEPS;
  localparam logic [31:0] RND_Z = (PB < 32) ? (32'd1 << (31 - PB)) : 32'd0;

  typedef enum logic [1:0] {
    REG_ANALYSIS_HOP  = 2'd0,
    REG_SYNTH_HOP     = 2'd1,
    REG_HOP_RATIO     = 2'd2
  } reg_idx_t;

  // config registers
  logic [11:0] analysis_hop_r;
  logic [19:0] synthesis_hop_q8_r;
  logic [23:0] hop_ratio_q16_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      analysis_hop_r     <= 12'd512;
      synthesis_hop_q8_r <= 20'd131072;
      hop_ratio_q16_r    <= 24'd65536;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_ANALYSIS_HOP: analysis_hop_r     <= pwdata[11:0];
        REG_SYNTH_HOP:    synthesis_hop_q8_r <= pwdata[19:0];
        REG_HOP_RATIO:    hop_ratio_q16_r    <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_ANALYSIS_HOP: prdata = {20'd0, analysis_hop_r};
      REG_SYNTH_HOP:    prdata = {12'd0, synthesis_hop_q8_r};
      REG_HOP_RATIO:    prdata = {8'd0, hop_ratio_q16_r};
      default:          prdata = 32'd0;
    endcase
  end

  // pipe advances unless a finished word is held at the output
  logic en, in_acc, pv_r;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign in_acc   = in_valid && !in_stall;

  // phases valid flag follows the accepted word order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (in_acc) begin
      if (in_operation) begin
        pv_r <= 1'b0;
      end else if (in_last_bin) begin
        pv_r <= 1'b1;
      end
    end
  end

  // vectoring row entry: fold left half plane, add guard bits
  logic                 vv   [0:NS];
  logic signed [CW-1:0] vx   [0:NS];
  logic signed [CW-1:0] vy   [0:NS];
  logic signed [ZW-1:0] vz   [0:NS];
  side_t                vs   [0:NS];
  logic signed [CW-1:0] re_w, im_w;

  always_comb begin
    re_w         = CW'(in_bin_real);
    im_w         = CW'(in_bin_imag);
    vv[0]        = in_acc && !in_operation;
    vx[0]        = (in_bin_real[SAMP_W-1] ? -re_w : re_w) <<< GUARD_BITS;
    vy[0]        = (in_bin_real[SAMP_W-1] ? -im_w : im_w) <<< GUARD_BITS;
    vz[0]        = in_bin_real[SAMP_W-1] ? $signed({1'b0, 32'h8000_0000}) : '0;
    vs[0].idx    = in_bin_index;
    vs[0].re     = in_bin_real;
    vs[0].im     = in_bin_imag;
    vs[0].last   = in_last_bin;
    vs[0].pv     = pv_r;
    vs[0].zero   = (in_bin_real == '0) && (in_bin_imag == '0);
    vs[0].proc   = 1'b0;
  end

  for (genvar g = 0; g < NS; g++) begin : g_vec
    pva_cordic_cell #(.STEP(g), .VECT(1'b1)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .v_in(vv[g]), .x_in(vx[g]), .y_in(vy[g]), .z_in(vz[g]), .side_in(vs[g]),
      .v_r(vv[g+1]), .x_r(vx[g+1]), .y_r(vy[g+1]), .z_r(vz[g+1]), .side_r(vs[g+1])
    );
  end

  // round angle to phase bits; an exact zero bin has phase zero
  logic [31:0]    z_rnd;
  logic [PB-1:0]  ph;

  always_comb begin
    z_rnd = vz[NS][31:0] + RND_Z;
    ph    = vs[NS].zero ? '0 : z_rnd[31 -: PB];
  end

  logic                 pu_v;
  side_t                pu_side;
  logic [PB-1:0]        pu_sc;
  logic signed [CW-1:0] pu_mag;

  pva_phase_update #(
    .FFT_SIZE(FFT_SIZE), .NUM_BINS(NUM_BINS), .PHASE_BITS(PHASE_BITS)
  ) u_phase (
    .clk(clk), .rst_n(rst_n), .en(en),
    .analysis_hop(analysis_hop_r), .synthesis_hop_q8(synthesis_hop_q8_r),
    .hop_ratio_q16(hop_ratio_q16_r),
    .in_v(vv[NS]), .in_side(vs[NS]), .in_ph(ph), .in_mag(vx[NS]),
    .s4_v_r(pu_v), .s4_side_r(pu_side), .s4_sc_r(pu_sc), .s4_mag_r(pu_mag)
  );

  // rotating row entry: angle to 32-bit turns, fold outer half circle
  logic                 rv [0:NS];
  logic signed [CW-1:0] rx [0:NS];
  logic signed [CW-1:0] ry [0:NS];
  logic signed [ZW-1:0] rz [0:NS];
  side_t                rs [0:NS];
  logic [31:0]          z32;
  logic                 outer;

  always_comb begin
    z32    = 32'(pu_sc) << (32 - PB);
    outer  = z32[31] ^ z32[30];
    rv[0]  = pu_v;
    rx[0]  = outer ? -pu_mag : pu_mag;
    ry[0]  = '0;
    rz[0]  = ZW'($signed({z32[31] ^ outer, z32[30:0]}));
    rs[0]  = pu_side;
  end

  for (genvar g = 0; g < NS; g++) begin : g_rot
    pva_cordic_cell #(.STEP(g), .VECT(1'b0)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .v_in(rv[g]), .x_in(rx[g]), .y_in(ry[g]), .z_in(rz[g]), .side_in(rs[g]),
      .v_r(rv[g+1]), .x_r(rx[g+1]), .y_r(ry[g+1]), .z_r(rz[g+1]), .side_r(rs[g+1])
    );
  end

  // descale by inverse squared gain, then round and saturate
  logic                d1_v_r;
  side_t               d1_side_r;
  logic signed [63:0]  d1_px_r, d1_py_r, dx, dy;
  logic signed [SAMP_W-1:0] sat_x, sat_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r <= 1'b0;
    end else if (en) begin
      d1_v_r <= rv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_side_r <= rs[NS];
      d1_px_r   <= 64'(rx[NS]) * INV_GAIN2_Q30;
      d1_py_r   <= 64'(ry[NS]) * INV_GAIN2_Q30;
    end
  end

  always_comb begin
    dx = (d1_px_r + 64'sd34359738368) >>> (30 + GUARD_BITS);
    dy = (d1_py_r + 64'sd34359738368) >>> (30 + GUARD_BITS);
    if (dx > 64'sd8388607) begin
      sat_x = 24'sh7FFFFF;
    end else if (dx < -64'sd8388608) begin
      sat_x = 24'sh800000;
    end else begin
      sat_x = dx[SAMP_W-1:0];
    end
    if (dy > 64'sd8388607) begin
      sat_y = 24'sh7FFFFF;
    end else if (dy < -64'sd8388608) begin
      sat_y = 24'sh800000;
    end else begin
      sat_y = dy[SAMP_W-1:0];
    end
  end

  // output register
  logic                     out_valid_r, out_last_r;
  logic [IDX_W-1:0]         out_index_r;
  logic signed [SAMP_W-1:0] out_real_r, out_imag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_index_r <= d1_side_r.idx;
      out_last_r  <= d1_side_r.last;
      out_real_r  <= d1_side_r.proc ? sat_x : d1_side_r.re;
      out_imag_r  <= d1_side_r.proc ? sat_y : d1_side_r.im;
    end
  end

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_real  = out_real_r;
  assign out_imag  = out_imag_r;
  assign out_last  = out_last_r;

  // a restart always leaves the phase memories marked not valid
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_operation |=> !pv_r)
    else $error("restart did not clear phases valid");

  // the last bin of a frame always marks the memories valid
  a_last_sets: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_operation && in_last_bin |=> pv_r)
    else $error("last bin did not set phases valid");

  // a frozen pipe holds the valids of the descale stage and the output register
  a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(d1_v_r) && $stable(out_valid_r))
    else $error("pipe moved while output held");

  // a restart never enters the cordic row
  a_restart_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_operation |-> !vv[0])
    else $error("restart word entered the pipe");

endmodule
